/* rtl/msdd_pkg.sv */
// ----------------------------------------------------------------------------
// msdd_pkg
// Shared types, constants and glyph functions for the segment display driver.
// ----------------------------------------------------------------------------
package msdd_pkg;

	// Display geometry: two segment bytes (outer, inner) per digit
	localparam int DIGITS        = 4;
	localparam int PATTERN_BYTES = 2 * DIGITS;
	localparam int SCAN_W        = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
	localparam int DIG_W         = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	// Field widths
	localparam int NUM_W  = 16;
	localparam int BASE_W = 6;
	localparam int CODE_W = 6;
	localparam int SEG_W  = 7;
	localparam int SEL_W  = 16;

	localparam int GLYPH_COUNT = 40;

	// Glyph codes and radix limits
	localparam logic [CODE_W-1:0] CODE_SPACE     = 6'd36;
	localparam logic [CODE_W-1:0] CODE_MINUS     = 6'd37;
	localparam logic [CODE_W-1:0] CODE_UNDERLINE = 6'd38;
	localparam logic [CODE_W-1:0] CODE_STAR      = 6'd39;
	localparam logic [CODE_W-1:0] CODE_LETTER_A  = 6'd10;
	localparam logic [BASE_W-1:0] RADIX_MIN      = 6'd2;
	localparam logic [BASE_W-1:0] RADIX_MAX      = 6'd36;

	// Active-low segment bytes
	localparam logic [SEG_W-1:0] BLANK_BYTE = 7'h7F;
	localparam logic [SEG_W-1:0] FULL_BYTE  = 7'h00;

	// Command codes
	typedef enum logic [2:0] {
		OP_WRITE_CHAR   = 3'd0,
		OP_BLANK_FROM   = 3'd1,
		OP_SHOW_NUMBER  = 3'd2,
		OP_CLEAR        = 3'd3,
		OP_TEST_PATTERN = 3'd4,
		OP_REFRESH      = 3'd5
	} op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_LAUNCH = 3'b010,
		ST_DIV    = 3'b100
	} state_t;

	// Divider request and response
	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  dividend;
		logic [BASE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [NUM_W-1:0]  quotient;
		logic [BASE_W-1:0] remainder;
	} div_rsp_t;

	// Glyph tables, outer and inner byte
	localparam logic [SEG_W-1:0] GLYPH_OUTER [GLYPH_COUNT] = '{
		7'h01, 7'h4F, 7'h12, 7'h06, 7'h4C, 7'h24, 7'h20, 7'h0F, 7'h00, 7'h04,
		7'h08, 7'h30, 7'h31, 7'h79, 7'h30, 7'h38, 7'h21, 7'h48, 7'h7F, 7'h43,
		7'h78, 7'h71, 7'h49, 7'h49, 7'h01, 7'h18, 7'h01, 7'h18, 7'h24, 7'h3F,
		7'h41, 7'h79, 7'h49, 7'h7F, 7'h7F, 7'h37, 7'h7F, 7'h7E, 7'h77, 7'h7E
	};

	localparam logic [SEG_W-1:0] GLYPH_INNER [GLYPH_COUNT] = '{
		7'h7F, 7'h7F, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h7F, 7'h3F, 7'h3F,
		7'h3F, 7'h73, 7'h7F, 7'h5E, 7'h7F, 7'h7F, 7'h3F, 7'h3F, 7'h6D, 7'h7F,
		7'h73, 7'h7F, 7'h57, 7'h5B, 7'h7F, 7'h3F, 7'h7B, 7'h3B, 7'h3F, 7'h6D,
		7'h7F, 7'h76, 7'h7A, 7'h52, 7'h55, 7'h76, 7'h7F, 7'h3F, 7'h7F, 7'h00
	};

	// ASCII to glyph code; anything unknown maps to space
	function automatic logic [CODE_W-1:0] char_code(input logic [7:0] ch);
		logic [CODE_W-1:0] code;
		code = CODE_SPACE;
		if (ch == 8'h2D) begin
			code = CODE_MINUS;
		end else if (ch == 8'h5F) begin
			code = CODE_UNDERLINE;
		end else if (ch == 8'h2A) begin
			code = CODE_STAR;
		end else if (ch >= 8'h30 && ch <= 8'h39) begin
			code = CODE_W'(ch - 8'h30);
		end else if (ch >= 8'h41 && ch <= 8'h5A) begin
			code = CODE_W'(ch - 8'h41) + CODE_LETTER_A;
		end else if (ch >= 8'h61 && ch <= 8'h7A) begin
			code = CODE_W'(ch - 8'h61) + CODE_LETTER_A;
		end
		return code;
	endfunction

	function automatic logic [SEG_W-1:0] glyph_outer(input logic [CODE_W-1:0] code);
		logic [SEG_W-1:0] seg;
		seg = BLANK_BYTE;
		if (int'(code) < GLYPH_COUNT) begin
			seg = GLYPH_OUTER[code];
		end
		return seg;
	endfunction

	function automatic logic [SEG_W-1:0] glyph_inner(input logic [CODE_W-1:0] code);
		logic [SEG_W-1:0] seg;
		seg = BLANK_BYTE;
		if (int'(code) < GLYPH_COUNT) begin
			seg = GLYPH_INNER[code];
		end
		return seg;
	endfunction

	// Pair select word: bits 2k and 2k+1 for scan index k, zero past bit 15
	function automatic logic [SEL_W-1:0] select_word(input logic [SCAN_W-1:0] idx);
		logic [SEL_W-1:0] sel;
		sel = '0;
		for (int k = 0; k < SEL_W / 2; k++) begin
			if (int'(idx) == k) begin
				sel[2*k +: 2] = 2'b11;
			end
		end
		return sel;
	endfunction

endpackage

/* rtl/msdd_div.sv */
// ----------------------------------------------------------------------------
// msdd_div
// Restoring radix divider, one quotient bit per cycle, shared by all digits.
// ----------------------------------------------------------------------------
module msdd_div (
	input  logic                clk,
	input  logic                arst_n,
	input  msdd_pkg::div_req_t  req,
	output msdd_pkg::div_rsp_t  rsp
);

	localparam int CNT_W = $clog2(msdd_pkg::NUM_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [msdd_pkg::NUM_W-1:0]  quo_q;
	logic [msdd_pkg::BASE_W-1:0] rem_q;

	logic [msdd_pkg::BASE_W:0]   trial;
	logic [msdd_pkg::BASE_W:0]   diff;
	logic                        fits;

	// Trial subtract of the shifted partial remainder
	always_comb begin
		trial = {rem_q, quo_q[msdd_pkg::NUM_W-1]};
		diff  = trial - {1'b0, req.divisor};
		fits  = (trial >= {1'b0, req.divisor});
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(msdd_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[msdd_pkg::NUM_W-2:0], fits};
			rem_q <= fits ? msdd_pkg::BASE_W'(diff) : msdd_pkg::BASE_W'(trial);
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

/* rtl/multiplexed_segment_display_driver_core.sv */
// Write char, blank from, clear and test pattern take effect at acceptance.
// A refresh tick presents its transaction on the output in the cycle after acceptance.
// Show number stalls the input while it converts: each shown digit takes a launch,
// the divider steps and a write-back, and each blanked digit takes a launch.
// Throughput: one transaction per cycle except during show number or a stalled output.
// Reset: all segment bytes blank (0x7F), scan index zero, output empty.
// ----------------------------------------------------------------------------
// multiplexed_segment_display_driver_core
// Segment byte store, command decode, number conversion sequencer and scan output.
// ----------------------------------------------------------------------------
module multiplexed_segment_display_driver_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [1:0]  position,
	input  logic [7:0]  character,
	input  logic [15:0] number,
	input  logic [5:0]  base,
	input  logic [7:0]  lit_segment,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] scan_select,
	output logic [7:0]  segment_pattern
);

	localparam int PB = msdd_pkg::PATTERN_BYTES;

	msdd_pkg::state_t            state_q;
	logic [msdd_pkg::DIG_W-1:0]  digit_q;
	logic [msdd_pkg::NUM_W-1:0]  rest_q;
	logic [msdd_pkg::BASE_W-1:0] radix_q;
	logic [msdd_pkg::SCAN_W-1:0] scan_q;
	logic [msdd_pkg::SEG_W-1:0]  pat_q [PB];

	logic                        out_valid_q;
	logic [msdd_pkg::SEL_W-1:0]  scan_select_q;
	logic [7:0]                  segment_pattern_q;

	logic                        in_acc;
	logic [PB-1:0]               pat_we;
	logic [msdd_pkg::SEG_W-1:0]  pat_wd [PB];
	logic [msdd_pkg::CODE_W-1:0] char_cd;
	logic [msdd_pkg::SCAN_W-1:0] scan_next;
	logic [msdd_pkg::BASE_W-1:0] radix_clamped;
	logic                        need_div;
	logic                        last_digit;

	msdd_pkg::div_req_t          div_req;
	msdd_pkg::div_rsp_t          div_rsp;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != msdd_pkg::ST_IDLE) || (out_valid_q && out_stall);

	assign char_cd    = msdd_pkg::char_code(character);
	assign scan_next  = (scan_q == msdd_pkg::SCAN_W'(PB - 1)) ? '0 : scan_q + 1'b1;
	assign need_div   = (rest_q != '0) || (digit_q == msdd_pkg::DIG_W'(msdd_pkg::DIGITS - 1));
	assign last_digit = (digit_q == '0);

	always_comb begin
		radix_clamped = base;
		if (base < msdd_pkg::RADIX_MIN) begin
			radix_clamped = msdd_pkg::RADIX_MIN;
		end else if (base > msdd_pkg::RADIX_MAX) begin
			radix_clamped = msdd_pkg::RADIX_MAX;
		end
	end

	// Shared divider
	assign div_req.start    = (state_q == msdd_pkg::ST_LAUNCH) && need_div;
	assign div_req.dividend = rest_q;
	assign div_req.divisor  = radix_q;

	msdd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Segment byte write enables and data
	always_comb begin
		pat_we = '0;
		for (int i = 0; i < PB; i++) begin
			pat_wd[i] = msdd_pkg::BLANK_BYTE;
		end
		if (in_acc) begin
			case (msdd_pkg::op_t'(operation))
				msdd_pkg::OP_WRITE_CHAR: begin
					for (int d = 0; d < msdd_pkg::DIGITS; d++) begin
						if (int'(position) == d) begin
							pat_we[2*d]     = 1'b1;
							pat_we[2*d+1]   = 1'b1;
							pat_wd[2*d]     = msdd_pkg::glyph_outer(char_cd);
							pat_wd[2*d+1]   = msdd_pkg::glyph_inner(char_cd);
						end
					end
				end
				msdd_pkg::OP_BLANK_FROM: begin
					for (int d = 0; d < msdd_pkg::DIGITS; d++) begin
						if (d >= int'(position)) begin
							pat_we[2*d]   = 1'b1;
							pat_we[2*d+1] = 1'b1;
						end
					end
				end
				msdd_pkg::OP_CLEAR: begin
					pat_we = '1;
				end
				msdd_pkg::OP_TEST_PATTERN: begin
					pat_we = '1;
					for (int i = 0; i < PB; i++) begin
						if (int'(lit_segment) == i) begin
							pat_wd[i] = msdd_pkg::FULL_BYTE;
						end
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == msdd_pkg::ST_LAUNCH && !need_div) begin
			// leading blank digit
			for (int d = 0; d < msdd_pkg::DIGITS; d++) begin
				if (int'(digit_q) == d) begin
					pat_we[2*d]   = 1'b1;
					pat_we[2*d+1] = 1'b1;
				end
			end
		end else if (state_q == msdd_pkg::ST_DIV && div_rsp.done) begin
			// converted digit
			for (int d = 0; d < msdd_pkg::DIGITS; d++) begin
				if (int'(digit_q) == d) begin
					pat_we[2*d]   = 1'b1;
					pat_we[2*d+1] = 1'b1;
					pat_wd[2*d]   = msdd_pkg::glyph_outer(div_rsp.remainder);
					pat_wd[2*d+1] = msdd_pkg::glyph_inner(div_rsp.remainder);
				end
			end
		end
	end

	// Segment byte store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PB; i++) begin
				pat_q[i] <= msdd_pkg::BLANK_BYTE;
			end
		end else begin
			for (int i = 0; i < PB; i++) begin
				if (pat_we[i]) begin
					pat_q[i] <= pat_wd[i];
				end
			end
		end
	end

	// Number conversion sequencer, rightmost digit first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msdd_pkg::ST_IDLE;
			digit_q <= '0;
		end else begin
			case (state_q)
				msdd_pkg::ST_IDLE: begin
					if (in_acc && msdd_pkg::op_t'(operation) == msdd_pkg::OP_SHOW_NUMBER) begin
						state_q <= msdd_pkg::ST_LAUNCH;
						digit_q <= msdd_pkg::DIG_W'(msdd_pkg::DIGITS - 1);
					end
				end
				msdd_pkg::ST_LAUNCH: begin
					if (need_div) begin
						state_q <= msdd_pkg::ST_DIV;
					end else if (last_digit) begin
						state_q <= msdd_pkg::ST_IDLE;
					end else begin
						digit_q <= digit_q - 1'b1;
					end
				end
				msdd_pkg::ST_DIV: begin
					if (div_rsp.done) begin
						if (last_digit) begin
							state_q <= msdd_pkg::ST_IDLE;
						end else begin
							state_q <= msdd_pkg::ST_LAUNCH;
							digit_q <= digit_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= msdd_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Operand registers for the conversion
	always_ff @(posedge clk) begin
		if (in_acc && msdd_pkg::op_t'(operation) == msdd_pkg::OP_SHOW_NUMBER) begin
			rest_q  <= number;
			radix_q <= radix_clamped;
		end else if (state_q == msdd_pkg::ST_DIV && div_rsp.done) begin
			rest_q <= div_rsp.quotient;
		end
	end

	// Scan index and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc && msdd_pkg::op_t'(operation) == msdd_pkg::OP_REFRESH) begin
				scan_q      <= scan_next;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && msdd_pkg::op_t'(operation) == msdd_pkg::OP_REFRESH) begin
			scan_select_q     <= msdd_pkg::select_word(scan_next);
			segment_pattern_q <= {1'b0, pat_q[scan_next]};
		end
	end

	assign out_valid       = out_valid_q;
	assign scan_select     = scan_select_q;
	assign segment_pattern = segment_pattern_q;

endmodule

/* rtl/msdd_checker.sv */
// ----------------------------------------------------------------------------
// msdd_checker
// Port-level checks for the segment display driver, bound to the top level.
// ----------------------------------------------------------------------------
module msdd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [2:0]  operation,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] scan_select,
	input logic [7:0]  segment_pattern
);

	// A held result blocks new commands
	a_out_hold_stalls_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input accepted while result held");

	// A number conversion keeps the input stalled in the next cycle
	a_show_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && operation == msdd_pkg::OP_SHOW_NUMBER |=> in_stall)
		else $error("no stall after show number");

	// Each result sets exactly one pair of select bits and carries a 7-bit segment byte
	a_pair_select: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones(scan_select) == 2 && !segment_pattern[7])
		else $error("bad select word or segment byte");

	// Stalled result stays put
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(scan_select)
			&& $stable(segment_pattern))
		else $error("stalled result changed");

endmodule

bind multiplexed_segment_display_driver_core msdd_checker u_msdd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.operation       (operation),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.scan_select     (scan_select),
	.segment_pattern (segment_pattern)
);

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the segment display driver core against an in-bench model of the
// segment byte store and the scan index. Every command transaction updates
// the model when it is accepted. Each refresh tick queues the scan frame it
// should produce, and the output monitor compares every delivered frame with
// the oldest queued one. Both handshakes idle and stall at random, with some
// stretches at full rate.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int RANDOM_ITEMS  = 1900;
	localparam int WATCHDOG_IDLE = 2000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int MAX_WAIT      = 19;

	// Operation codes the block decodes as no-ops
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	// Glyph codes used by the model
	localparam int GC_LETTER_A  = 10;
	localparam int GC_SPACE     = 36;
	localparam int GC_MINUS     = 37;
	localparam int GC_UNDERLINE = 38;
	localparam int GC_STAR      = 39;
	localparam int GC_COUNT     = 40;

	localparam int N_DIGITS = 4;
	localparam int N_BYTES  = 2 * N_DIGITS;

	localparam logic [6:0] SEG_BLANK = 7'h7F;
	localparam logic [6:0] SEG_FULL  = 7'h00;

	localparam logic [6:0] OUTER_SEG [GC_COUNT] = '{
		7'h01, 7'h4F, 7'h12, 7'h06, 7'h4C, 7'h24, 7'h20, 7'h0F, 7'h00, 7'h04,
		7'h08, 7'h30, 7'h31, 7'h79, 7'h30, 7'h38, 7'h21, 7'h48, 7'h7F, 7'h43,
		7'h78, 7'h71, 7'h49, 7'h49, 7'h01, 7'h18, 7'h01, 7'h18, 7'h24, 7'h3F,
		7'h41, 7'h79, 7'h49, 7'h7F, 7'h7F, 7'h37, 7'h7F, 7'h7E, 7'h77, 7'h7E
	};

	localparam logic [6:0] INNER_SEG [GC_COUNT] = '{
		7'h7F, 7'h7F, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h7F, 7'h3F, 7'h3F,
		7'h3F, 7'h73, 7'h7F, 7'h5E, 7'h7F, 7'h7F, 7'h3F, 7'h3F, 7'h6D, 7'h7F,
		7'h73, 7'h7F, 7'h57, 7'h5B, 7'h7F, 7'h3F, 7'h7B, 7'h3B, 7'h3F, 7'h6D,
		7'h7F, 7'h76, 7'h7A, 7'h52, 7'h55, 7'h76, 7'h7F, 7'h3F, 7'h7F, 7'h00
	};

	typedef struct {
		logic [15:0] select;
		logic [7:0]  pattern;
	} scan_frame_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  operation;
	logic [1:0]  position;
	logic [7:0]  character;
	logic [15:0] number;
	logic [5:0]  base;
	logic [7:0]  lit_segment;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] scan_select;
	logic [7:0]  segment_pattern;

	// Model state
	logic [6:0]  shown_bytes [N_BYTES];
	logic [2:0]  scan_pos;
	scan_frame_t frames_due [$];

	int  mismatch_count;
	bit  steady_flow;

	multiplexed_segment_display_driver_core DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.position        (position),
		.character       (character),
		.number          (number),
		.base            (base),
		.lit_segment     (lit_segment),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.scan_select     (scan_select),
		.segment_pattern (segment_pattern)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Display model
	// ------------------------------------------------------------------
	function automatic int glyph_code(input logic [7:0] ch);
		if (ch == " ") return GC_SPACE;
		if (ch == "-") return GC_MINUS;
		if (ch == "_") return GC_UNDERLINE;
		if (ch == "*") return GC_STAR;
		if (ch >= "0" && ch <= "9") return int'(ch) - int'("0");
		if (ch >= "A" && ch <= "Z") return int'(ch) - int'("A") + GC_LETTER_A;
		if (ch >= "a" && ch <= "z") return int'(ch) - int'("a") + GC_LETTER_A;
		return GC_SPACE;
	endfunction

	function automatic void place_glyph(input int digit, input int code);
		if (digit >= N_DIGITS || code >= GC_COUNT) return;
		shown_bytes[2 * digit]     = OUTER_SEG[code];
		shown_bytes[2 * digit + 1] = INNER_SEG[code];
	endfunction

	function automatic void model_reset();
		foreach (shown_bytes[i]) shown_bytes[i] = SEG_BLANK;
		scan_pos = '0;
	endfunction

	// Apply one accepted command; a refresh tick queues its frame
	function automatic void apply_command(input logic [2:0] op, input logic [1:0] pos,
		input logic [7:0] ch, input logic [15:0] num, input logic [5:0] radix_in,
		input logic [7:0] lit);
		int          rest;
		int          radix;
		scan_frame_t frame;
		case (op)
			msdd_pkg::OP_WRITE_CHAR: begin
				place_glyph(int'(pos), glyph_code(ch));
			end
			msdd_pkg::OP_BLANK_FROM: begin
				for (int d = int'(pos); d < N_DIGITS; d++) place_glyph(d, GC_SPACE);
			end
			msdd_pkg::OP_SHOW_NUMBER: begin
				rest  = int'(num);
				radix = int'(radix_in);
				if (radix < 2) radix = 2;
				if (radix > 36) radix = 36;
				// right-aligned, leading blanks, high digits dropped
				for (int d = N_DIGITS - 1; d >= 0; d--) begin
					if (rest != 0 || d == N_DIGITS - 1) begin
						place_glyph(d, rest % radix);
						rest = rest / radix;
					end else begin
						place_glyph(d, GC_SPACE);
					end
				end
			end
			msdd_pkg::OP_CLEAR: begin
				for (int d = 0; d < N_DIGITS; d++) place_glyph(d, GC_SPACE);
			end
			msdd_pkg::OP_TEST_PATTERN: begin
				for (int b = 0; b < N_BYTES; b++)
					shown_bytes[b] = (int'(lit) == b) ? SEG_FULL : SEG_BLANK;
			end
			msdd_pkg::OP_REFRESH: begin
				// index advances before the frame goes out
				scan_pos      = scan_pos + 3'd1;
				frame.select  = {14'b0, 2'b11} << {scan_pos, 1'b0};
				frame.pattern = {1'b0, shown_bytes[scan_pos]};
				frames_due.push_back(frame);
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Command driver: one transaction, with a random lead-in gap
	// ------------------------------------------------------------------
	task automatic send_command(input logic [2:0] op, input logic [1:0] pos,
		input logic [7:0] ch, input logic [15:0] num, input logic [5:0] radix_in,
		input logic [7:0] lit);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		position    <= pos;
		character   <= ch;
		number      <= num;
		base        <= radix_in;
		lit_segment <= lit;
		do @(posedge clk); while (in_stall);
		apply_command(op, pos, ch, num, radix_in, lit);
	endtask

	task automatic send_refresh();
		send_command(msdd_pkg::OP_REFRESH, 2'($urandom), 8'($urandom), 16'($urandom),
			6'($urandom), 8'($urandom));
	endtask

	function automatic logic [7:0] pick_character();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 255));
			1: return 8'("0" + $urandom_range(0, 9));
			2: return 8'(($urandom_range(0, 1) ? "A" : "a") + $urandom_range(0, 25));
			default: begin
				case ($urandom_range(0, 3))
					0: return " ";
					1: return "-";
					2: return "_";
					default: return "*";
				endcase
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Output side: random stall per frame, check every delivered frame
	// ------------------------------------------------------------------
	initial begin : scan_receiver
		int hold;
		@(posedge arst_n);
		forever begin
			hold = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
			@(negedge clk);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	always @(posedge clk) begin : scan_checker
		scan_frame_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (frames_due.size() == 0) begin
				$error("unexpected scan frame: scan_select %h segment_pattern %h",
					scan_select, segment_pattern);
				mismatch_count++;
			end else begin
				due = frames_due.pop_front();
				if (scan_select !== due.select) begin
					$error("scan_select: expected %h, actual %h", due.select, scan_select);
					mismatch_count++;
				end
				if (segment_pattern !== due.pattern) begin
					$error("segment_pattern: expected %h, actual %h", due.pattern,
						segment_pattern);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: too long without any transaction on either side
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_IDLE) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("testbench failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Blank display after reset, scan index wraps through all eight bytes
	task automatic test_scan_wrap();
		repeat (N_BYTES) send_refresh();
	endtask

	// Characters of each class, including an unknown byte above 127
	task automatic test_write_char();
		send_command(msdd_pkg::OP_WRITE_CHAR, 2'd0, "-", 16'h0, 6'd10, 8'd0);
		send_command(msdd_pkg::OP_WRITE_CHAR, 2'd1, "9", 16'h0, 6'd10, 8'd0);
		send_command(msdd_pkg::OP_WRITE_CHAR, 2'd2, "a", 16'h0, 6'd10, 8'd0);
		send_command(msdd_pkg::OP_WRITE_CHAR, 2'd3, 8'hFF, 16'h0, 6'd10, 8'd0);
		repeat (2) send_refresh();
	endtask

	// Zero, largest value, truncation, radix clamped at both ends
	task automatic test_show_number();
		send_command(msdd_pkg::OP_SHOW_NUMBER, 2'd0, 8'd0, 16'd0, 6'd10, 8'd0);
		send_command(msdd_pkg::OP_SHOW_NUMBER, 2'd0, 8'd0, 16'hFFFF, 6'd36, 8'd0);
		send_command(msdd_pkg::OP_SHOW_NUMBER, 2'd0, 8'd0, 16'hFFFF, 6'd2, 8'd0);
		send_command(msdd_pkg::OP_SHOW_NUMBER, 2'd0, 8'd0, 16'd5, 6'd0, 8'd0);
		send_command(msdd_pkg::OP_SHOW_NUMBER, 2'd0, 8'd0, 16'hABCD, 6'd63, 8'd0);
		send_refresh();
	endtask

	// Blank from, clear, test pattern edges and the spare opcodes
	task automatic test_blank_clear_pattern();
		send_command(msdd_pkg::OP_BLANK_FROM, 2'd2, 8'd0, 16'd0, 6'd10, 8'd0);
		send_command(msdd_pkg::OP_CLEAR, 2'd0, 8'd0, 16'd0, 6'd10, 8'd0);
		send_command(msdd_pkg::OP_TEST_PATTERN, 2'd0, 8'd0, 16'd0, 6'd10, 8'd0);
		send_command(msdd_pkg::OP_TEST_PATTERN, 2'd0, 8'd0, 16'd0, 6'd10, 8'd7);
		send_command(msdd_pkg::OP_TEST_PATTERN, 2'd0, 8'd0, 16'd0, 6'd10, 8'd255);
		send_command(OP_SPARE_LO, 2'd3, 8'hFF, 16'hFFFF, 6'd63, 8'hFF);
		send_command(OP_SPARE_HI, 2'd0, 8'd0, 16'd0, 6'd0, 8'd0);
		send_refresh();
	endtask

	// Random mix: refresh ticks, strings closed by blank-from, plus loose commands
	task automatic test_random_traffic();
		int          done_items;
		int          len;
		int          pick;
		logic [5:0]  radix_in;
		logic [15:0] num;
		done_items = 0;
		while (done_items < RANDOM_ITEMS) begin
			if (done_items % 150 == 0) steady_flow = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				// one string, closed by blank-from when it is short
				len = $urandom_range(0, N_DIGITS);
				for (int d = 0; d < len; d++) begin
					send_command(msdd_pkg::OP_WRITE_CHAR, 2'(d), pick_character(),
						16'($urandom), 6'($urandom), 8'($urandom));
				end
				if (len < N_DIGITS) begin
					send_command(msdd_pkg::OP_BLANK_FROM, 2'(len), 8'($urandom),
						16'($urandom), 6'($urandom), 8'($urandom));
				end
				done_items += (len < N_DIGITS) ? len + 1 : len;
			end else if (pick < 55) begin
				send_refresh();
				done_items++;
			end else if (pick < 67) begin
				send_command(msdd_pkg::OP_WRITE_CHAR, 2'($urandom), pick_character(),
					16'($urandom), 6'($urandom), 8'($urandom));
				done_items++;
			end else if (pick < 77) begin
				radix_in = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
					: 6'($urandom_range(2, 36));
				case ($urandom_range(0, 2))
					0: num = 16'($urandom_range(0, 15));
					1: num = 16'($urandom_range(0, 255));
					default: num = 16'($urandom_range(0, 65535));
				endcase
				send_command(msdd_pkg::OP_SHOW_NUMBER, 2'($urandom), 8'($urandom), num,
					radix_in, 8'($urandom));
				done_items++;
			end else if (pick < 82) begin
				send_command(msdd_pkg::OP_BLANK_FROM, 2'($urandom), 8'($urandom),
					16'($urandom), 6'($urandom), 8'($urandom));
				done_items++;
			end else if (pick < 86) begin
				send_command(msdd_pkg::OP_CLEAR, 2'($urandom), 8'($urandom), 16'($urandom),
					6'($urandom), 8'($urandom));
				done_items++;
			end else if (pick < 94) begin
				send_command(msdd_pkg::OP_TEST_PATTERN, 2'($urandom), 8'($urandom),
					16'($urandom), 6'($urandom), $urandom_range(0, 1)
					? 8'($urandom_range(0, 9)) : 8'($urandom));
				done_items++;
			end else begin
				// spare opcodes are ignored by the block
				send_command($urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI,
					2'($urandom), 8'($urandom), 16'($urandom), 6'($urandom), 8'($urandom));
				done_items++;
			end
		end
		steady_flow = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		operation      = msdd_pkg::OP_WRITE_CHAR;
		position       = '0;
		character      = '0;
		number         = '0;
		base           = 6'd10;
		lit_segment    = '0;
		out_stall      = 1'b0;
		mismatch_count = 0;
		steady_flow    = 1'b0;
		model_reset();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_scan_wrap();
		test_write_char();
		test_show_number();
		test_blank_clear_pattern();
		test_random_traffic();

		@(negedge clk);
		in_valid <= 1'b0;
		while (frames_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
